// File: src/spm_pkg.sv
`default_nettype none

package spm_pkg;

  // default sizes of the match stores
  localparam int WINDOW_LEN_DEF = 11;
  localparam int SUFFIX_MAX_DEF = 9;

  // character codes
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // keyword dictionary, right aligned: last character in the low byte, zero padded
  localparam int N_KW     = 11;
  localparam int KW_BYTES = 11;
  localparam logic [KW_BYTES*8-1:0] KW_TEXT [N_KW] = '{
    "password", "secret", "credential", {"private", "_key"}, "id_rsa",
    "id_dsa", {"id_ec", "dsa"}, ".gitconfig", ".htpasswd", "token", "apikey"
  };

  // extension dictionary without the dot, right aligned like the keywords
  localparam int N_EXT     = 18;
  localparam int EXT_BYTES = 8;
  localparam int EXT_LEN_W = 4;
  localparam logic [EXT_BYTES*8-1:0] EXT_TEXT [N_EXT] = '{
    "key", "pem", "pfx", "p12", "cer", "crt", "der", "jks", "keystore",
    "env", "htpasswd", "sql", "sqlite", "sqlite3", "db",
    "csv", "xls", "xlsx"
  };
  localparam logic [EXT_LEN_W-1:0] EXT_LEN [N_EXT] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd8,
    4'd3, 4'd8, 4'd3, 4'd6, 4'd7, 4'd2,
    4'd3, 4'd3, 4'd4
  };

  // one request on the input channel
  typedef struct packed {
    logic [7:0] path_char;
    logic       last_char;
  } in_t;

  // one verdict on the result channel
  typedef struct packed {
    logic sensitive;
    logic keyword_hit;
    logic extension_hit;
  } out_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sensitive_path_matcher.sv
// sensitive path matcher
//
// in channel: one path byte per request (in_data.path_char), with
// in_data.last_char marking the final byte. letters are folded to lower
// case before matching. out channel: one verdict per path, carrying
// keyword_hit, extension_hit and their or as sensitive.
//
// throughput: one byte per cycle while in_ready is high. the keyword window
// and the suffix store update in the cycle a byte is taken, and the verdict
// of the last byte is loaded into the output register at that same edge, so
// it shows on out_valid in the cycle after the last byte is accepted.
//
// reset clears all match state and out_valid, but not out_data. state also
// clears after every last byte, so the next byte starts a new path.
//
// receiver stall: the verdict holds in the output register; in_ready stays
// high while that register is empty or being taken in the same cycle, and
// drops only when a verdict is waiting and out_ready is low.
`default_nettype none

module sensitive_path_matcher #(
  parameter int WINDOW_LEN = spm_pkg::WINDOW_LEN_DEF,
  parameter int SUFFIX_MAX = spm_pkg::SUFFIX_MAX_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire spm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output spm_pkg::out_t      out_data
);
  import spm_pkg::*;

  logic  in_fire;
  out_t  verdict;
  logic  out_valid_r;
  out_t  out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  spm_scan #(
    .WINDOW_LEN(WINDOW_LEN),
    .SUFFIX_MAX(SUFFIX_MAX)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_fire),
    .req    (in_data),
    .verdict(verdict)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_data.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_char) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_sensitive_is_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.sensitive ==
                     (out_data_r.keyword_hit || out_data_r.extension_hit)))
    else $error("sensitive does not match its hit flags");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_char) |=> out_valid_r)
    else $error("last byte accepted without a verdict");

  a_inner_byte_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.last_char) |=> !out_valid_r)
    else $error("verdict appeared after an inner byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled with the output register free");
`endif

endmodule

`default_nettype wire

// File: src/spm_scan.sv
`default_nettype none

module spm_scan #(
  parameter int WINDOW_LEN = spm_pkg::WINDOW_LEN_DEF,
  parameter int SUFFIX_MAX = spm_pkg::SUFFIX_MAX_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire spm_pkg::in_t req,
  output spm_pkg::out_t     verdict
);
  import spm_pkg::*;

  localparam int WIN_W = WINDOW_LEN * 8;
  localparam int SUF_W = SUFFIX_MAX * 8;
  localparam int LEN_W = $clog2(SUFFIX_MAX + 1);

  logic [WIN_W-1:0] window_r, window_nxt;
  logic             kw_seen_r, kw_seen_nxt;
  logic [SUF_W-1:0] suffix_r, suffix_nxt;
  logic [LEN_W-1:0] suf_len_r, suf_len_nxt;
  logic             dot_seen_r, dot_seen_nxt;
  logic             overflow_r, overflow_nxt;

  logic [7:0] ch;
  logic       kw_now;
  logic       ext_now;

  assign ch = fold_case(req.path_char);

  // window shift, newest byte at the low end
  always_comb begin
    window_nxt = {window_r[WIN_W-9:0], ch};
  end

  // parallel keyword compare on the newest bytes
  always_comb begin
    logic       ok;
    logic [7:0] kb;
    kw_now = 1'b0;
    for (int k = 0; k < N_KW; k++) begin
      ok = 1'b1;
      for (int j = 0; j < KW_BYTES; j++) begin
        kb = KW_TEXT[k][8*j +: 8];
        if (kb != 8'h00 && window_nxt[8*j +: 8] != kb) begin
          ok = 1'b0;
        end
      end
      kw_now = kw_now | ok;
    end
  end

  assign kw_seen_nxt = kw_seen_r | kw_now;

  // suffix after the last dot, shifted in like the window
  always_comb begin
    suffix_nxt   = suffix_r;
    suf_len_nxt  = suf_len_r;
    dot_seen_nxt = dot_seen_r;
    overflow_nxt = overflow_r;
    if (ch == CHAR_DOT) begin
      dot_seen_nxt = 1'b1;
      suf_len_nxt  = '0;
      overflow_nxt = 1'b0;
      suffix_nxt   = '0;
    end else if (dot_seen_r && !overflow_r) begin
      if (suf_len_r < LEN_W'(SUFFIX_MAX)) begin
        suffix_nxt  = {suffix_r[SUF_W-9:0], ch};
        suf_len_nxt = suf_len_r + 1'b1;
      end else begin
        overflow_nxt = 1'b1;
      end
    end
  end

  // exact extension compare, unused high bytes are always zero
  always_comb begin
    logic any;
    any = 1'b0;
    for (int k = 0; k < N_EXT; k++) begin
      if (suf_len_nxt == LEN_W'(EXT_LEN[k]) && suffix_nxt == SUF_W'(EXT_TEXT[k])) begin
        any = 1'b1;
      end
    end
    ext_now = any && dot_seen_nxt && !overflow_nxt;
  end

  // verdict fields: sensitive, keyword_hit, extension_hit
  assign verdict = {kw_seen_nxt | ext_now, kw_seen_nxt, ext_now};

  // match state, cleared after the last byte of a path
  always_ff @(posedge clk) begin
    if (!rst_n || (step && req.last_char)) begin
      window_r   <= '0;
      kw_seen_r  <= 1'b0;
      suffix_r   <= '0;
      suf_len_r  <= '0;
      dot_seen_r <= 1'b0;
      overflow_r <= 1'b0;
    end else if (step) begin
      window_r   <= window_nxt;
      kw_seen_r  <= kw_seen_nxt;
      suffix_r   <= suffix_nxt;
      suf_len_r  <= suf_len_nxt;
      dot_seen_r <= dot_seen_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule

`default_nettype wire
